// ===== hw/rtl/cik_pkg.sv =====
package cik_pkg;

    localparam int KERNEL_SIZE = 3;
    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 4096;

    localparam int KTAPS = KERNEL_SIZE * KERNEL_SIZE;
    localparam int KHALF = KERNEL_SIZE / 2;

    localparam int PIX_W      = 8;
    localparam int COEF_W     = 16;
    localparam int COEF_IDX_W = 4;
    localparam int PROD_W     = PIX_W + COEF_W + 1;
    localparam int RSUM_W     = PROD_W + $clog2(KERNEL_SIZE);
    localparam int RESULT_W   = 32;

    localparam int ROW_W    = 12;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int WIDTH_W  = $clog2(MAX_WIDTH + 1);
    localparam int HEIGHT_W = $clog2(MAX_HEIGHT + 1);

    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 13;
    localparam int IMG_W_FIELD_W = 12;
    localparam int IMG_H_FIELD_W = 13;

    localparam int LINE_W = (KERNEL_SIZE - 1) * PIX_W;

    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [0:0] {
        REQ_PIXEL = 1'b0,
        REQ_COEF  = 1'b1
    } req_type_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } meta_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] value;
        meta_t                      meta;
    } result_t;

    function automatic logic [WIDTH_W-1:0] clamp_width(input logic [IMG_W_FIELD_W-1:0] v);
        if (v == '0)
            return WIDTH_W'(1);
        else if (32'(v) > MAX_WIDTH)
            return WIDTH_W'(MAX_WIDTH);
        else
            return WIDTH_W'(v);
    endfunction

    function automatic logic [HEIGHT_W-1:0] clamp_height(input logic [IMG_H_FIELD_W-1:0] v);
        if (v == '0)
            return HEIGHT_W'(1);
        else if (32'(v) > MAX_HEIGHT)
            return HEIGHT_W'(MAX_HEIGHT);
        else
            return HEIGHT_W'(v);
    endfunction

endpackage

// ===== hw/rtl/cik_ram.sv =====
module cik_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/cik_tap_cell.sv =====
module cik_tap_cell (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  shift_en,
    input  logic [cik_pkg::PIX_W-1:0]             pix_in,
    input  logic                                  coef_we,
    input  logic signed [cik_pkg::COEF_W-1:0]     coef_in,
    output logic [cik_pkg::PIX_W-1:0]             pix_out,
    output logic signed [cik_pkg::PROD_W-1:0]     prod
);

    logic [cik_pkg::PIX_W-1:0]         pix_reg;
    logic signed [cik_pkg::COEF_W-1:0] coef_reg;
    logic signed [cik_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_reg  <= '0;
            coef_reg <= '0;
        end
        else
        begin
            if (shift_en)
            begin
                pix_reg <= pix_in;
            end
            if (coef_we)
            begin
                coef_reg <= coef_in;
            end
        end
    end

    // The product is taken every cycle from the window and coefficient as they stand.
    always_ff @(posedge clk)
    begin
        prod_reg <= $signed({1'b0, pix_reg}) * coef_reg;
    end

    assign pix_out = pix_reg;
    assign prod    = prod_reg;

endmodule

// ===== hw/rtl/cik_out_fifo.sv =====
module cik_out_fifo (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    input  cik_pkg::result_t                   push_data,
    input  logic                               pop,
    output cik_pkg::result_t                   head,
    output logic                               not_empty,
    output logic [cik_pkg::FIFO_CNT_W-1:0]     count
);

    cik_pkg::result_t                  mem_reg [cik_pkg::FIFO_DEPTH];
    logic [cik_pkg::FIFO_PTR_W-1:0]    wr_ptr_reg;
    logic [cik_pkg::FIFO_PTR_W-1:0]    rd_ptr_reg;
    logic [cik_pkg::FIFO_CNT_W-1:0]    count_reg;
    logic [cik_pkg::FIFO_CNT_W-1:0]    count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + cik_pkg::FIFO_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - cik_pkg::FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + cik_pkg::FIFO_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + cik_pkg::FIFO_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

// ===== hw/rtl/conv2d_integer_kernel_unit.sv =====
// Streaming KERNEL_SIZE x KERNEL_SIZE integer convolution over raster-order 8-bit pixels.
// One request is taken per clock unless stalled, pixel or coefficient load alike; interior window
// centers give a result and border centers give none. The window is a grid of tap cells, each
// holding one pixel and one coefficient and registering its product; row sums are registered, and
// the final sum is formed as it enters an eight-entry output queue that lets the input keep
// flowing while results wait. The input stalls only when eight results are pending. Older rows
// live in one single-port-write line RAM read one column ahead. A coefficient load takes effect
// for the next pixel. Writing either image size register restarts the frame at row 0, column 0;
// configure only while idle.
module conv2d_integer_kernel_unit (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic                                     req_type,
    input  logic [cik_pkg::PIX_W-1:0]                pixel,
    input  logic [cik_pkg::COEF_IDX_W-1:0]           coef_index,
    input  logic signed [cik_pkg::COEF_W-1:0]        coef_value,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic signed [cik_pkg::RESULT_W-1:0]      result_value,
    output logic [cik_pkg::ROW_W-1:0]                out_row,
    output logic [cik_pkg::COL_W-1:0]                out_col,
    output logic                                     frame_last,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [cik_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [cik_pkg::CFG_DATA_W-1:0]           cfg_data
);

    localparam int K = cik_pkg::KERNEL_SIZE;

    logic [cik_pkg::WIDTH_W-1:0]  width_reg;
    logic [cik_pkg::HEIGHT_W-1:0] height_reg;
    logic [cik_pkg::ROW_W-1:0]    row_reg;
    logic [cik_pkg::ROW_W-1:0]    row_next;
    logic [cik_pkg::COL_W-1:0]    col_reg;
    logic [cik_pkg::COL_W-1:0]    col_next;
    logic [cik_pkg::WIDTH_W-1:0]  col_inc;
    logic [cik_pkg::HEIGHT_W-1:0] row_inc;

    logic in_acc;
    logic pix_acc;
    logic coef_acc;
    logic cfg_acc;
    logic out_acc;
    logic emit;
    logic last_center;

    logic [cik_pkg::LINE_W-1:0] ram_rdata;
    logic [cik_pkg::LINE_W-1:0] line_rdata;
    logic [cik_pkg::LINE_W-1:0] line_wdata;
    logic [cik_pkg::LINE_W-1:0] byp_data_reg;
    logic                       byp_hit_reg;
    logic [cik_pkg::PIX_W-1:0]  column [K];

    logic [cik_pkg::PIX_W-1:0]         cell_pix  [cik_pkg::KTAPS];
    logic [cik_pkg::PIX_W-1:0]         cell_in   [cik_pkg::KTAPS];
    logic signed [cik_pkg::PROD_W-1:0] cell_prod [cik_pkg::KTAPS];
    logic                              cell_we   [cik_pkg::KTAPS];

    logic signed [cik_pkg::RSUM_W-1:0]   rsum_next [K];
    logic signed [cik_pkg::RSUM_W-1:0]   rsum_reg  [K];
    logic signed [cik_pkg::RESULT_W-1:0] total;

    logic            s0_valid_reg;
    logic            s1_valid_reg;
    logic            s2_valid_reg;
    cik_pkg::meta_t  meta0_reg;
    cik_pkg::meta_t  meta1_reg;
    cik_pkg::meta_t  meta2_reg;
    cik_pkg::result_t fifo_in;
    cik_pkg::result_t fifo_head;
    logic [cik_pkg::FIFO_CNT_W-1:0] fifo_count;

    logic [cik_pkg::FIFO_CNT_W-1:0] pend_reg;
    logic [cik_pkg::FIFO_CNT_W-1:0] pend_next;

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign in_ready  = (pend_reg < cik_pkg::FIFO_CNT_W'(cik_pkg::FIFO_DEPTH));
    assign in_acc    = in_valid && in_ready;
    assign pix_acc   = in_acc && (req_type == cik_pkg::REQ_PIXEL);
    assign coef_acc  = in_acc && (req_type == cik_pkg::REQ_COEF);
    assign out_acc   = out_valid && out_ready;

    assign emit = pix_acc
               && (row_reg >= cik_pkg::ROW_W'(K - 1))
               && (col_reg >= cik_pkg::COL_W'(K - 1));

    assign last_center = (cik_pkg::HEIGHT_W'(row_reg) == height_reg - cik_pkg::HEIGHT_W'(1))
                      && (cik_pkg::WIDTH_W'(col_reg) == width_reg - cik_pkg::WIDTH_W'(1));

    // Raster position counters.
    always_comb
    begin
        col_inc  = cik_pkg::WIDTH_W'(col_reg) + cik_pkg::WIDTH_W'(1);
        row_inc  = cik_pkg::HEIGHT_W'(row_reg) + cik_pkg::HEIGHT_W'(1);
        col_next = col_reg;
        row_next = row_reg;
        priority if (cfg_acc)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (pix_acc)
        begin
            if (col_inc >= width_reg)
            begin
                col_next = '0;
                if (row_inc >= height_reg)
                    row_next = '0;
                else
                    row_next = row_inc[cik_pkg::ROW_W-1:0];
            end
            else
            begin
                col_next = col_inc[cik_pkg::COL_W-1:0];
            end
        end
        else
        begin
            col_next = col_reg;
            row_next = row_reg;
        end
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (emit && !out_acc)
            pend_next = pend_reg + cik_pkg::FIFO_CNT_W'(1);
        else if (out_acc && !emit)
            pend_next = pend_reg - cik_pkg::FIFO_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= cik_pkg::WIDTH_W'(640);
            height_reg   <= cik_pkg::HEIGHT_W'(480);
            row_reg      <= '0;
            col_reg      <= '0;
            byp_hit_reg  <= 1'b0;
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            pend_reg     <= '0;
        end
        else
        begin
            if (cfg_acc)
            begin
                unique case (cfg_index)
                    cik_pkg::CFG_IMAGE_WIDTH:
                        width_reg <= cik_pkg::clamp_width(
                            cfg_data[cik_pkg::IMG_W_FIELD_W-1:0]);
                    cik_pkg::CFG_IMAGE_HEIGHT:
                        height_reg <= cik_pkg::clamp_height(
                            cfg_data[cik_pkg::IMG_H_FIELD_W-1:0]);
                    default:
                        ;
                endcase
            end
            row_reg      <= row_next;
            col_reg      <= col_next;
            byp_hit_reg  <= pix_acc && (col_next == col_reg);
            s0_valid_reg <= emit;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            pend_reg     <= pend_next;
        end
    end

    // Line RAM: read one column ahead; a write to the address being read is forwarded.
    cik_ram #(
        .WIDTH (cik_pkg::LINE_W),
        .DEPTH (cik_pkg::MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .we      (pix_acc),
        .wr_addr (col_reg),
        .wr_data (line_wdata),
        .rd_addr (col_next),
        .rd_data (ram_rdata)
    );

    assign line_rdata = byp_hit_reg ? byp_data_reg : ram_rdata;

    always_comb
    begin
        for (int r = 0; r < K - 1; r++)
        begin
            column[r] = line_rdata[r*cik_pkg::PIX_W +: cik_pkg::PIX_W];
        end
        column[K-1] = pixel;
        for (int r = 0; r < K - 1; r++)
        begin
            line_wdata[r*cik_pkg::PIX_W +: cik_pkg::PIX_W] = column[r+1];
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= line_wdata;
        if (emit)
        begin
            meta0_reg.row  <= row_reg - cik_pkg::ROW_W'(cik_pkg::KHALF);
            meta0_reg.col  <= col_reg - cik_pkg::COL_W'(cik_pkg::KHALF);
            meta0_reg.last <= last_center;
        end
        meta1_reg <= meta0_reg;
        meta2_reg <= meta1_reg;
        for (int r = 0; r < K; r++)
        begin
            rsum_reg[r] <= rsum_next[r];
        end
    end

    // Each window row is a chain of cells shifting left; the new column enters at the right.
    for (genvar r = 0; r < K; r++)
    begin : g_row
        for (genvar k = 0; k < K; k++)
        begin : g_tap
            localparam int IDX = r * K + k;

            if (k == K - 1)
            begin : g_edge
                assign cell_in[IDX] = column[r];
            end
            else
            begin : g_inner
                assign cell_in[IDX] = cell_pix[IDX+1];
            end

            assign cell_we[IDX] = coef_acc && (coef_index == cik_pkg::COEF_IDX_W'(IDX));

            cik_tap_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (pix_acc),
                .pix_in   (cell_in[IDX]),
                .coef_we  (cell_we[IDX]),
                .coef_in  (coef_value),
                .pix_out  (cell_pix[IDX]),
                .prod     (cell_prod[IDX])
            );
        end
    end

    always_comb
    begin
        for (int r = 0; r < K; r++)
        begin
            rsum_next[r] = '0;
            for (int k = 0; k < K; k++)
            begin
                rsum_next[r] = rsum_next[r] + cik_pkg::RSUM_W'(cell_prod[r*K+k]);
            end
        end
        total = '0;
        for (int r = 0; r < K; r++)
        begin
            total = total + cik_pkg::RESULT_W'(rsum_reg[r]);
        end
    end

    assign fifo_in.value = total;
    assign fifo_in.meta  = meta2_reg;

    cik_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s2_valid_reg),
        .push_data (fifo_in),
        .pop       (out_acc),
        .head      (fifo_head),
        .not_empty (out_valid),
        .count     (fifo_count)
    );

    assign result_value = fifo_head.value;
    assign out_row      = fifo_head.meta.row;
    assign out_col      = fifo_head.meta.col;
    assign frame_last   = fifo_head.meta.last;

`ifndef SYNTHESIS
    a_pend_matches: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == fifo_count + cik_pkg::FIFO_CNT_W'(s0_valid_reg)
                    + cik_pkg::FIFO_CNT_W'(s1_valid_reg) + cik_pkg::FIFO_CNT_W'(s2_valid_reg))
        else $error("pending count disagrees with items in flight");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (fifo_count < cik_pkg::FIFO_CNT_W'(cik_pkg::FIFO_DEPTH)))
        else $error("result pushed into a full output queue");

    a_coef_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        coef_acc |=> !s0_valid_reg)
        else $error("coefficient load started a result");

    a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_acc |=> (row_reg == '0 && col_reg == '0))
        else $error("register write did not restart the frame");
`endif

endmodule
